/* sv/image_upscale_2x_interpolate_core_assert.svh */
// Assertion macros for the 2x interpolating upscaler.
// Uses the clock and reset of the module that includes it.
`ifndef IMAGE_UPSCALE_2X_INTERPOLATE_CORE_ASSERT_SVH
`define IMAGE_UPSCALE_2X_INTERPOLATE_CORE_ASSERT_SVH

// Same-cycle implication.
`define IU2X_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define IU2X_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/iu2x_pkg.sv */
// Shared constants and helpers for the 2x interpolating upscaler.
// No dependencies.
package iu2x_pkg;

   localparam int PIX_W          = 8;
   localparam int DIM_W          = 11;
   localparam int COORD_W        = 11;
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_PAD_W  = RSP_DATA_W - 2 * COORD_W - PIX_W;

   // result slots: group (output row kind) by position in the row segment
   localparam int NUM_POS   = 3;
   localparam int NUM_SLOT  = 9;
   localparam int GRP_EVEN  = 0;
   localparam int GRP_ODD   = 1;
   localparam int GRP_FINAL = 2;
   localparam int POS_MID   = 0;
   localparam int POS_CUR   = 1;
   localparam int POS_END   = 2;

   localparam logic CSR_WIDTH_IN  = 1'b0;
   localparam logic CSR_HEIGHT_IN = 1'b1;

   function automatic logic [PIX_W-1:0] mean2(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
      logic [PIX_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[PIX_W:1];
   endfunction

endpackage

/* sv/image_upscale_2x_interpolate_core.sv */
// Top level of the 2x interpolating upscaler: counters, line buffer, result sequencer.
// Depends on iu2x_pkg, iu2x_ram and image_upscale_2x_interpolate_core_assert.svh.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tdata: pixel
//  rsp     | out | rsp_tvalid/tready    | tdata: out_row, out_col, value; tlast; tuser
//  csr     | in  | csr_we               | csr_index, csr_wdata
//
// Words are registered in the input stage; the result sequencer emits one result
// word per cycle unless rsp stalls, 1 to 9 per input word (about 4 on average), so
// the rsp port sets the rate. The next input word is taken while results are emitted.
// Synchronous reset clears control state; the line buffer needs no clearing.
// A stalled rsp holds the result register and backs up through the stages.
`include "image_upscale_2x_interpolate_core_assert.svh"

module image_upscale_2x_interpolate_core import iu2x_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: pixel[7:0]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // rsp_tdata: out_row[10:0], out_col[21:11], value[29:22], zero pad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   // rsp_tuser: frame_done[0]
   output logic                  rsp_tuser,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [DIM_W-1:0]      csr_wdata
);

   localparam int CW = (MAX_WIDTH > 1)  ? $clog2(MAX_WIDTH)  : 1;
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int EW = ($clog2(MAX_WIDTH + 1) > DIM_W)  ? $clog2(MAX_WIDTH + 1)  : DIM_W;
   localparam int EH = ($clog2(MAX_HEIGHT + 1) > DIM_W) ? $clog2(MAX_HEIGHT + 1) : DIM_W;
   localparam logic [EW-1:0] MAXW = EW'(MAX_WIDTH);
   localparam logic [EH-1:0] MAXH = EH'(MAX_HEIGHT);

   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic [PIX_W-1:0] left;
      logic [CW-1:0]    col;
      logic [RW-1:0]    row;
      logic             last_col;
      logic             last_row;
   } stage_a_type;

   typedef struct packed {
      logic [PIX_W-1:0]   pix;
      logic [PIX_W-1:0]   even_mid;
      logic [PIX_W-1:0]   odd_mid;
      logic [PIX_W-1:0]   odd_cur;
      logic [COORD_W-1:0] row_even;
      logic [COORD_W-1:0] row_odd;
      logic [COORD_W-1:0] row_final;
      logic [COORD_W-1:0] col_mid;
      logic [COORD_W-1:0] col_cur;
      logic [COORD_W-1:0] col_end;
      logic               last_col;
      logic               last_row;
   } stage_b_type;

   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [PIX_W-1:0]   value;
      logic               last;
      logic               frame_done;
   } result_type;

   logic [DIM_W-1:0] width_ff, width_in, height_ff, height_in;
   logic [CW-1:0]    col_ff, col_in, col_sel;
   logic [RW-1:0]    row_ff, row_in, row_sel;
   logic [PIX_W-1:0] left_ff, left_in, last_above_ff, last_above_in;
   logic [EW-1:0]    w_eff;
   logic [EH-1:0]    h_eff;
   logic             col_last, row_last;

   logic             a_valid_ff, a_valid_in, b_valid_ff, b_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   stage_a_type      a_ff, a_in;
   stage_b_type      b_ff, b_in;
   result_type       rsp_ff, rsp_in;
   logic [NUM_SLOT-1:0] rem_ff, rem_in, new_mask, slot_oh, rem_after;

   logic             accept, a_to_b, rsp_load, b_finish;
   logic [PIX_W-1:0] above, even_mid, above_mid;
   logic             grp_odd, grp_final, pos_mid, pos_cur;
   logic [CW:0]      col2x;
   logic [RW:0]      row2x;

   // effective dimensions, clamped to 1..max
   always_comb begin
      if (width_ff == '0) begin
         w_eff = EW'(1);
      end else if (EW'(width_ff) > MAXW) begin
         w_eff = MAXW;
      end else begin
         w_eff = EW'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = EH'(1);
      end else if (EH'(height_ff) > MAXH) begin
         h_eff = MAXH;
      end else begin
         h_eff = EH'(height_ff);
      end
   end

   assign col_sel  = (EW'(col_ff) >= w_eff) ? '0 : col_ff;
   assign row_sel  = (EH'(row_ff) >= h_eff) ? '0 : row_ff;
   assign col_last = (EW'(col_sel) == w_eff - EW'(1));
   assign row_last = (EH'(row_sel) == h_eff - EH'(1));

   // handshake
   assign rsp_load   = b_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign slot_oh    = rem_ff & (~rem_ff + NUM_SLOT'(1));
   assign rem_after  = rem_ff & ~slot_oh;
   assign b_finish   = rsp_load && (rem_after == '0);
   assign a_to_b     = a_valid_ff && (!b_valid_ff || b_finish);
   assign req_tready = !a_valid_ff || a_to_b;
   assign accept     = req_tvalid && req_tready;

   iu2x_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH),
      .AW    (CW)
   ) u_line (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_sel),
      .wr_data (req_tdata[PIX_W-1:0]),
      .rd_en   (accept),
      .rd_addr (col_sel),
      .rd_data (above)
   );

   // config and position counters
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      left_in   = left_ff;
      if (csr_we) begin
         if (csr_index == CSR_WIDTH_IN) begin
            width_in = csr_wdata;
         end else begin
            height_in = csr_wdata;
         end
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         left_in = req_tdata[PIX_W-1:0];
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_sel + RW'(1);
         end else begin
            col_in = col_sel + CW'(1);
            row_in = row_sel;
         end
      end
   end

   // input stage
   always_comb begin
      a_valid_in = accept ? 1'b1 : (a_to_b ? 1'b0 : a_valid_ff);
      a_in       = a_ff;
      if (accept) begin
         a_in.pix      = req_tdata[PIX_W-1:0];
         a_in.left     = left_ff;
         a_in.col      = col_sel;
         a_in.row      = row_sel;
         a_in.last_col = col_last;
         a_in.last_row = row_last;
      end
   end

   // interpolation into the sequencer stage
   assign even_mid  = mean2(a_ff.left, a_ff.pix);
   assign above_mid = mean2(last_above_ff, above);
   assign col2x     = {a_ff.col, 1'b0};
   assign row2x     = {a_ff.row, 1'b0};

   always_comb begin
      new_mask = '0;
      new_mask[GRP_EVEN * NUM_POS + POS_MID]  = (a_ff.col != '0);
      new_mask[GRP_EVEN * NUM_POS + POS_CUR]  = 1'b1;
      new_mask[GRP_EVEN * NUM_POS + POS_END]  = a_ff.last_col;
      if (a_ff.row != '0) begin
         new_mask[GRP_ODD * NUM_POS + POS_MID] = (a_ff.col != '0);
         new_mask[GRP_ODD * NUM_POS + POS_CUR] = 1'b1;
         new_mask[GRP_ODD * NUM_POS + POS_END] = a_ff.last_col;
      end
      if (a_ff.last_row) begin
         new_mask[GRP_FINAL * NUM_POS + POS_MID] = (a_ff.col != '0);
         new_mask[GRP_FINAL * NUM_POS + POS_CUR] = 1'b1;
         new_mask[GRP_FINAL * NUM_POS + POS_END] = a_ff.last_col;
      end
   end

   always_comb begin
      b_valid_in    = a_to_b ? 1'b1 : (b_finish ? 1'b0 : b_valid_ff);
      rem_in        = a_to_b ? new_mask : (rsp_load ? rem_after : rem_ff);
      last_above_in = a_to_b ? above : last_above_ff;
      b_in          = b_ff;
      if (a_to_b) begin
         b_in.pix       = a_ff.pix;
         b_in.even_mid  = even_mid;
         b_in.odd_mid   = mean2(above_mid, even_mid);
         b_in.odd_cur   = mean2(above, a_ff.pix);
         b_in.row_even  = COORD_W'(row2x);
         b_in.row_odd   = COORD_W'(row2x - (RW + 1)'(1));
         b_in.row_final = COORD_W'({h_eff, 1'b0} - (EH + 1)'(1));
         b_in.col_mid   = COORD_W'(col2x - (CW + 1)'(1));
         b_in.col_cur   = COORD_W'(col2x);
         b_in.col_end   = COORD_W'({w_eff, 1'b0} - (EW + 1)'(1));
         b_in.last_col  = a_ff.last_col;
         b_in.last_row  = a_ff.last_row;
      end
   end

   // result selection
   assign grp_odd   = |slot_oh[GRP_ODD * NUM_POS +: NUM_POS];
   assign grp_final = |slot_oh[GRP_FINAL * NUM_POS +: NUM_POS];
   assign pos_mid   = slot_oh[GRP_EVEN * NUM_POS + POS_MID] |
                      slot_oh[GRP_ODD * NUM_POS + POS_MID] |
                      slot_oh[GRP_FINAL * NUM_POS + POS_MID];
   assign pos_cur   = slot_oh[GRP_EVEN * NUM_POS + POS_CUR] |
                      slot_oh[GRP_ODD * NUM_POS + POS_CUR] |
                      slot_oh[GRP_FINAL * NUM_POS + POS_CUR];

   always_comb begin
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_in       = rsp_ff;
      if (rsp_load) begin
         rsp_in.row = grp_odd ? b_ff.row_odd : (grp_final ? b_ff.row_final : b_ff.row_even);
         rsp_in.col = pos_mid ? b_ff.col_mid : (pos_cur ? b_ff.col_cur : b_ff.col_end);
         if (grp_odd) begin
            rsp_in.value = pos_mid ? b_ff.odd_mid : b_ff.odd_cur;
         end else begin
            rsp_in.value = pos_mid ? b_ff.even_mid : b_ff.pix;
         end
         rsp_in.last       = (rem_after == '0);
         rsp_in.frame_done = (rem_after == '0) && b_ff.last_col && b_ff.last_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= DIM_W'(1);
         height_ff     <= DIM_W'(1);
         col_ff        <= '0;
         row_ff        <= '0;
         left_ff       <= '0;
         last_above_ff <= '0;
         a_valid_ff    <= 1'b0;
         b_valid_ff    <= 1'b0;
         rem_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         width_ff      <= width_in;
         height_ff     <= height_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         left_ff       <= left_in;
         last_above_ff <= last_above_in;
         a_valid_ff    <= a_valid_in;
         b_valid_ff    <= b_valid_in;
         rem_ff        <= rem_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), rsp_ff.value, rsp_ff.col, rsp_ff.row};
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tuser  = rsp_ff.frame_done;

   `IU2X_ASSERT_IMP(a_seq_live, b_valid_ff, rem_ff != '0, "sequencer holds a word with no results")
   `IU2X_ASSERT_NEXT(a_seq_load, a_to_b, b_valid_ff && (rem_ff != '0), "word lost on load")
   `IU2X_ASSERT_IMP(a_slot_one, rsp_load, $onehot(slot_oh), "result slot not one-hot")
   `IU2X_ASSERT_IMP(a_done_last, rsp_valid_ff && rsp_ff.frame_done, rsp_ff.last, "stray frame end")
   `IU2X_ASSERT_IMP(a_col_range, !csr_we, EW'(col_ff) < w_eff, "column counter beyond width")

endmodule

/* sv/iu2x_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// Read-first on a same-address collision. No dependencies.
module iu2x_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
